// ===== design/ostt_pkg.sv =====
// Shared types and constants for the one-shot timer event table.
// No dependencies; imported by every module of the block.
package ostt_pkg;

    // Operation codes carried in the func field
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_ARM    = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

    // Most expirations reported by one tick
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int HANDLE_W = 8;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 10;
    localparam int SLOT_W   = 3;

    // One slot entry held in the slot memory
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   due;
    } entry_t;

    // One result word handed from the sequencer to the output register
    typedef struct packed {
        logic                fired;
        logic [HANDLE_W-1:0] event_handle;
        logic [SLOT_W-1:0]   slot_index;
        logic [1:0]          status;
        logic [TIME_W-1:0]   now_ms;
        logic                last;
    } res_t;

endpackage

// ===== design/ostt_slot_mem.sv =====
// Slot memory: handle and due time per slot, one write and one read port.
// Read data is registered. Uses ostt_pkg.
module ostt_slot_mem
    import ostt_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; hold data while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ostt_seq.sv =====
// Sequencer: time counter, armed bits and the slot scan for tick, arm and cancel.
// Drives the slot memory ports and pushes result words. Uses ostt_pkg.
module ostt_seq
    import ostt_pkg::*;
#(
    parameter int SLOTS  = 8,
    parameter int ADDR_W = 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [TIME_W-1:0]   delay,
    input  logic [MS_W-1:0]     ms_per_tick,
    input  logic                out_free,
    output logic                push,
    output res_t                push_word,
    output logic                mem_wr_en,
    output logic [ADDR_W-1:0]   mem_wr_addr,
    output entry_t              mem_wr_data,
    output logic                mem_rd_en,
    output logic [ADDR_W-1:0]   mem_rd_addr,
    input  entry_t              mem_rd_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [SLOTS-1:0]    armed_reg, armed_next;
    logic [1:0]          op_reg, op_next;
    logic [HANDLE_W-1:0] hnd_reg, hnd_next;
    logic [TIME_W-1:0]   due_in_reg, due_in_next;
    logic [ADDR_W:0]     scan_idx_reg, scan_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0]   chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]    fire_cnt_reg, fire_cnt_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [HANDLE_W-1:0] pend_hnd_reg, pend_hnd_next;
    logic [ADDR_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                found_reg, found_next;
    logic [ADDR_W-1:0]   found_idx_reg, found_idx_next;

    logic issue_ok;
    logic chk_armed;
    logic tick_hit;
    logic hit;
    logic freeze;

    // Scan state: next slot to read, slot under check
    assign issue_ok    = scan_idx_reg < (ADDR_W + 1)'(SLOTS);
    assign mem_rd_addr = scan_idx_reg[ADDR_W-1:0];
    assign chk_armed   = armed_reg[chk_idx_reg];
    assign tick_hit    = chk_armed && (mem_rd_data.due <= now_reg)
                         && (fire_cnt_reg < CNT_W'(MAX_RESULTS));

    always_comb
    begin
        case (op_reg)
            FUNC_TICK:   hit = chk_vld_reg && tick_hit;
            FUNC_ARM:    hit = chk_vld_reg && !chk_armed;
            FUNC_CANCEL: hit = chk_vld_reg && chk_armed
                               && (mem_rd_data.handle == hnd_reg);
            default:     hit = 1'b0;
        endcase
    end

    // Hold the scan when a pending expiration must go out but the output is busy
    assign freeze = hit && (op_reg == FUNC_TICK) && pend_vld_reg && !out_free;

    assign in_stall    = (state_reg != ST_IDLE);
    assign mem_wr_addr = chk_idx_reg;
    assign mem_wr_data = '{handle: hnd_reg, due: due_in_reg};

    // Next-state and result logic
    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        armed_next     = armed_reg;
        op_next        = op_reg;
        hnd_next       = hnd_reg;
        due_in_next    = due_in_reg;
        scan_idx_next  = scan_idx_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        fire_cnt_next  = fire_cnt_reg;
        pend_vld_next  = pend_vld_reg;
        pend_hnd_next  = pend_hnd_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        push           = 1'b0;
        push_word      = '0;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = func;
                    hnd_next      = handle;
                    due_in_next   = now_reg + ((delay == '0) ? TIME_W'(1) : delay);
                    scan_idx_next = '0;
                    chk_vld_next  = 1'b0;
                    fire_cnt_next = '0;
                    pend_vld_next = 1'b0;
                    found_next    = 1'b0;
                    if (func == FUNC_TICK)
                    begin
                        now_next   = now_reg + TIME_W'(ms_per_tick);
                        state_next = ST_SCAN;
                    end
                    else if (func inside {FUNC_ARM, FUNC_CANCEL})
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (!freeze)
                begin
                    // Advance the read pipeline by one slot
                    mem_rd_en    = issue_ok;
                    chk_vld_next = issue_ok;
                    chk_idx_next = mem_rd_addr;
                    if (issue_ok)
                    begin
                        scan_idx_next = scan_idx_reg + (ADDR_W + 1)'(1);
                    end

                    if (hit)
                    begin
                        case (op_reg)
                            FUNC_TICK:
                            begin
                                armed_next[chk_idx_reg] = 1'b0;
                                fire_cnt_next = fire_cnt_reg + CNT_W'(1);
                                if (pend_vld_reg)
                                begin
                                    push                   = 1'b1;
                                    push_word.fired        = 1'b1;
                                    push_word.event_handle = pend_hnd_reg;
                                    push_word.slot_index   = SLOT_W'(pend_idx_reg);
                                    push_word.status       = STAT_OK;
                                    push_word.now_ms       = now_reg;
                                    push_word.last         = 1'b0;
                                end
                                pend_vld_next = 1'b1;
                                pend_hnd_next = mem_rd_data.handle;
                                pend_idx_next = chk_idx_reg;
                            end
                            FUNC_ARM:
                            begin
                                armed_next[chk_idx_reg] = 1'b1;
                                mem_wr_en      = 1'b1;
                                found_next     = 1'b1;
                                found_idx_next = chk_idx_reg;
                                state_next     = ST_FINISH;
                            end
                            FUNC_CANCEL:
                            begin
                                armed_next[chk_idx_reg] = 1'b0;
                                found_next     = 1'b1;
                                found_idx_next = chk_idx_reg;
                                state_next     = ST_FINISH;
                            end
                            default:
                            begin
                                state_next = ST_FINISH;
                            end
                        endcase
                    end

                    if (!issue_ok && !chk_vld_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                // Send the closing word of the item
                if (out_free)
                begin
                    push             = 1'b1;
                    push_word.now_ms = now_reg;
                    push_word.last   = 1'b1;
                    push_word.status = STAT_OK;
                    if (op_reg == FUNC_TICK)
                    begin
                        if (pend_vld_reg)
                        begin
                            push_word.fired        = 1'b1;
                            push_word.event_handle = pend_hnd_reg;
                            push_word.slot_index   = SLOT_W'(pend_idx_reg);
                        end
                    end
                    else
                    begin
                        push_word.event_handle = hnd_reg;
                        if (found_reg)
                        begin
                            push_word.slot_index = SLOT_W'(found_idx_reg);
                        end
                        else if (op_reg == FUNC_ARM)
                        begin
                            push_word.status = STAT_FULL;
                        end
                        else
                        begin
                            push_word.status = STAT_NOT_FOUND;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            now_reg      <= '0;
            armed_reg    <= '0;
            op_reg       <= FUNC_TICK;
            scan_idx_reg <= '0;
            chk_vld_reg  <= 1'b0;
            fire_cnt_reg <= '0;
            pend_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            armed_reg    <= armed_next;
            op_reg       <= op_next;
            scan_idx_reg <= scan_idx_next;
            chk_vld_reg  <= chk_vld_next;
            fire_cnt_reg <= fire_cnt_next;
            pend_vld_reg <= pend_vld_next;
            found_reg    <= found_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        hnd_reg       <= hnd_next;
        due_in_reg    <= due_in_next;
        chk_idx_reg   <= chk_idx_next;
        pend_hnd_reg  <= pend_hnd_next;
        pend_idx_reg  <= pend_idx_next;
        found_idx_reg <= found_idx_next;
    end

    // Checks
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed while output register busy");

    a_tick_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && func == FUNC_TICK)
        |=> now_reg == $past(now_reg) + TIME_W'($past(ms_per_tick)))
        else $error("time counter did not advance on tick");

    a_wr_free: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> !armed_reg[mem_wr_addr])
        else $error("arm wrote into an armed slot");

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("fire count exceeded limit");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_word.last) |=> state_reg == ST_IDLE)
        else $error("closing word sent but item not finished");

endmodule

// ===== design/one_shot_timer_event_table_core.sv =====
// Top level of the one-shot timer event table: config register, output register,
// sequencer and slot memory. Uses ostt_pkg, ostt_seq and ostt_slot_mem.
//
// One item is worked at a time. Every operation scans the slot memory one slot
// per cycle, unless held for a busy output, through its single read port with
// registered read data: a tick scans every slot, an arm or cancel stops at the
// slot that matches (or scans all when none does). A tick that expires several
// slots sends one word per expiration; each word after the first waits for the
// previous one to leave the output register, so a stalled output lengthens the
// item. An unknown func code is taken without a scan and gives no word. A new
// item is taken as soon as the closing word of the last one sits in the output
// register. The timer memory needs no clearing after reset.
module one_shot_timer_event_table_core
    import ostt_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [MS_W-1:0]     cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [TIME_W-1:0]   delay,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                fired,
    output logic [HANDLE_W-1:0] event_handle,
    output logic [SLOT_W-1:0]   slot_index,
    output logic [1:0]          status,
    output logic [TIME_W-1:0]   now_ms,
    output logic                last
);

    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [MS_W-1:0]   ms_per_tick_reg;
    logic              out_valid_reg, out_valid_next;
    res_t              out_word_reg;
    logic              out_free;
    logic              push;
    res_t              push_word;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    entry_t            mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    entry_t            mem_rd_data;

    // Step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_per_tick_reg <= MS_W'(1);
        end
        else if (cfg_wr_en)
        begin
            ms_per_tick_reg <= cfg_wr_data;
        end
    end

    // Output register: load a pushed word, drop it when taken
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_word_reg <= push_word;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fired        = out_word_reg.fired;
    assign event_handle = out_word_reg.event_handle;
    assign slot_index   = out_word_reg.slot_index;
    assign status       = out_word_reg.status;
    assign now_ms       = out_word_reg.now_ms;
    assign last         = out_word_reg.last;

    ostt_seq #(
        .SLOTS  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .handle      (handle),
        .delay       (delay),
        .ms_per_tick (ms_per_tick_reg),
        .out_free    (out_free),
        .push        (push),
        .push_word   (push_word),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ostt_slot_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== sim/one_shot_timer_event_table_core_test.sv =====
// Self-checking test of one_shot_timer_event_table_core: directed and random
// tick, arm and cancel traffic, each result word checked against a predictor.
// Depends on ostt_pkg and the RTL of the block only.
module one_shot_timer_event_table_core_test;
    import ostt_pkg::*;

    localparam int SLOTS = 8;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] DELAY_MAX = '1;
    localparam int SETTLE_CYCLES = SLOTS + 12;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [MS_W-1:0]     cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          func;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic                out_valid;
    logic                out_stall;
    logic                fired;
    logic [HANDLE_W-1:0] event_handle;
    logic [SLOT_W-1:0]   slot_index;
    logic [1:0]          status;
    logic [TIME_W-1:0]   now_ms;
    logic                last;

    // Predicted timer table state
    logic [MS_W-1:0]     tick_step;
    logic [TIME_W-1:0]   tbl_now;
    logic                tbl_armed  [SLOTS];
    logic [HANDLE_W-1:0] tbl_handle [SLOTS];
    logic [TIME_W-1:0]   tbl_due    [SLOTS];

    res_t pending_words[$];
    int   fail_count = 0;
    int   report_count = 0;
    int   send_gap_max = 0;
    int   sink_gap_max = 0;
    int   sink_hold = 0;

    one_shot_timer_event_table_core #(.SLOTS(SLOTS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .handle       (handle),
        .delay        (delay),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fired        (fired),
        .event_handle (event_handle),
        .slot_index   (slot_index),
        .status       (status),
        .now_ms       (now_ms),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build one result word at the current predicted time
    function automatic res_t make_word(logic f, logic [HANDLE_W-1:0] h, int s,
                                       logic [1:0] st, logic l);
        res_t w;
        w.fired        = f;
        w.event_handle = h;
        w.slot_index   = s[SLOT_W-1:0];
        w.status       = st;
        w.now_ms       = tbl_now;
        w.last         = l;
        return w;
    endfunction

    // Advance the predicted table by one accepted word and queue its results
    task automatic apply_timer_op(input logic [1:0] op, input logic [HANDLE_W-1:0] hnd,
                                  input logic [TIME_W-1:0] dly);
        res_t word;
        bit   have;
        bit   done;
        int   n;
        logic [TIME_W-1:0] eff;
        have = 0;
        done = 0;
        n = 0;
        case (op)
            FUNC_TICK:
            begin
                tbl_now = tbl_now + tick_step;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (n < MAX_RESULTS && tbl_armed[i] && tbl_due[i] <= tbl_now)
                    begin
                        tbl_armed[i] = 1'b0;
                        if (have)
                            pending_words.push_back(word);
                        word = make_word(1'b1, tbl_handle[i], i, STAT_OK, 1'b0);
                        have = 1;
                        n++;
                    end
                end
                // Empty tick still reports one closing word
                if (!have)
                    word = make_word(1'b0, '0, 0, STAT_OK, 1'b1);
                else
                    word.last = 1'b1;
                pending_words.push_back(word);
            end
            FUNC_ARM:
            begin
                eff = (dly == '0) ? 32'd1 : dly;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && !tbl_armed[i])
                    begin
                        tbl_armed[i]  = 1'b1;
                        tbl_handle[i] = hnd;
                        tbl_due[i]    = tbl_now + eff;
                        pending_words.push_back(make_word(1'b0, hnd, i, STAT_OK, 1'b1));
                        done = 1;
                    end
                end
                if (!done)
                    pending_words.push_back(make_word(1'b0, hnd, 0, STAT_FULL, 1'b1));
            end
            FUNC_CANCEL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && tbl_armed[i] && tbl_handle[i] == hnd)
                    begin
                        tbl_armed[i] = 1'b0;
                        pending_words.push_back(make_word(1'b0, hnd, i, STAT_OK, 1'b1));
                        done = 1;
                    end
                end
                if (!done)
                    pending_words.push_back(make_word(1'b0, hnd, 0, STAT_NOT_FOUND, 1'b1));
            end
            default:
            begin
                // Unknown op: no state change, no word
            end
        endcase
    endtask

    // Offer one input word after a random gap; predict once it is taken
    task automatic offer_word(input logic [1:0] op, input logic [HANDLE_W-1:0] hnd,
                              input logic [TIME_W-1:0] dly);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        repeat (gap) @(negedge clk);
        func     = op;
        handle   = hnd;
        delay    = dly;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        apply_timer_op(op, hnd, dly);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Drain outstanding words, let the block settle, then write the step
    task automatic set_tick_step(input logic [MS_W-1:0] step);
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = step;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        tick_step   = step;
    endtask

    // Compare one taken result word with the oldest expectation
    task automatic check_result_word();
        res_t got;
        res_t want;
        got.fired        = fired;
        got.event_handle = event_handle;
        got.slot_index   = slot_index;
        got.status       = status;
        got.now_ms       = now_ms;
        got.last         = last;
        if (pending_words.size() == 0)
        begin
            fail_count++;
            if (report_count < 10)
                $display("unexpected word: fired=%0d handle=%0d slot=%0d status=%0d now=%0d last=%0d",
                         got.fired, got.event_handle, got.slot_index, got.status,
                         got.now_ms, got.last);
            report_count++;
        end
        else
        begin
            want = pending_words.pop_front();
            if (got !== want)
            begin
                fail_count++;
                if (report_count < 10)
                begin
                    $display("mismatch: expected fired=%0d handle=%0d slot=%0d status=%0d now=%0d last=%0d",
                             want.fired, want.event_handle, want.slot_index, want.status,
                             want.now_ms, want.last);
                    $display("          got      fired=%0d handle=%0d slot=%0d status=%0d now=%0d last=%0d",
                             got.fired, got.event_handle, got.slot_index, got.status,
                             got.now_ms, got.last);
                end
                report_count++;
            end
        end
    endtask

    // Result side: random stalls, an optional long hold, check each word taken
    initial
    begin : result_sink
        int wait_n;
        out_stall = 1'b1;
        forever
        begin
            if (sink_hold > 0)
            begin
                out_stall = 1'b1;
                repeat (sink_hold) @(negedge clk);
                sink_hold = 0;
            end
            wait_n = $urandom_range(0, sink_gap_max);
            if (wait_n > 0)
            begin
                out_stall = 1'b1;
                repeat (wait_n) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1 || rst_n !== 1'b1);
            check_result_word();
            @(negedge clk);
        end
    end

    // Pick a handle, favoring a small pool so cancels and duplicates hit
    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 3) == 0)
            return HANDLE_W'($urandom_range(0, 255));
        return HANDLE_W'($urandom_range(0, 7));
    endfunction

    // Pick a delay: mostly near the tick step so timers fire, some huge or wrapping
    function automatic logic [TIME_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            6, 7:    return $urandom_range(0, 50);
            8:       return $urandom();
            9:       return DELAY_MAX - $urandom_range(0, 3000);
            default: return $urandom_range(0, 4 * tick_step + 4);
        endcase
    endfunction

    task automatic random_item();
        int sel;
        int slot;
        logic [HANDLE_W-1:0] hnd;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            offer_word(FUNC_TICK, pick_handle(), $urandom());
        else if (sel < 70)
            offer_word(FUNC_ARM, pick_handle(), pick_delay());
        else if (sel < 92)
        begin
            // Prefer a handle that is armed right now
            hnd  = pick_handle();
            slot = $urandom_range(0, SLOTS - 1);
            if ($urandom_range(0, 9) < 6 && tbl_armed[slot])
                hnd = tbl_handle[slot];
            offer_word(FUNC_CANCEL, hnd, $urandom());
        end
        else
            offer_word(FUNC_UNUSED, pick_handle(), $urandom());
    endtask

    // Tick on an empty table and an unknown op
    task automatic test_idle_tick();
        offer_word(FUNC_TICK, 8'h00, 32'h0);
        offer_word(FUNC_UNUSED, 8'hA5, 32'h5A5A_5A5A);
        offer_word(FUNC_TICK, 8'hFF, DELAY_MAX);
    endtask

    // Zero delay, all-ones delay that wraps, both firing on one tick
    task automatic test_arm_limits();
        offer_word(FUNC_ARM, 8'h00, 32'h0);
        offer_word(FUNC_ARM, 8'hFF, DELAY_MAX);
        offer_word(FUNC_TICK, 8'h00, 32'h0);
    endtask

    // Duplicate handles: cancel takes the lowest slot, then not found
    task automatic test_cancel_lookup();
        offer_word(FUNC_ARM, 8'h07, 32'd100);
        offer_word(FUNC_ARM, 8'h07, 32'd100);
        offer_word(FUNC_CANCEL, 8'h07, 32'h0);
        offer_word(FUNC_CANCEL, 8'h09, 32'h0);
        offer_word(FUNC_CANCEL, 8'h07, 32'h0);
        offer_word(FUNC_CANCEL, 8'h07, 32'h0);
    endtask

    // Fill every slot, overflow once, then expire all on one large tick
    task automatic test_table_full();
        set_tick_step(10'd1000);
        for (int i = 0; i < SLOTS; i++)
            offer_word(FUNC_ARM, HANDLE_W'(8'h30 + i), 32'd5 + i);
        offer_word(FUNC_ARM, 8'hEE, 32'd5);
        offer_word(FUNC_TICK, 8'h00, 32'h0);
    endtask

    task automatic test_random_traffic(input int count, input logic [MS_W-1:0] step,
                                       input int sgap, input int rgap);
        set_tick_step(step);
        send_gap_max = sgap;
        sink_gap_max = rgap;
        repeat (count) random_item();
    endtask

    // Hold the result side for a long stretch while inputs keep coming
    task automatic test_output_backpressure();
        send_gap_max = 0;
        sink_gap_max = 0;
        sink_hold    = 400;
        repeat (24) random_item();
    endtask

    initial
    begin : run_sequence
        int guard;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        func        = FUNC_TICK;
        handle      = '0;
        delay       = '0;
        tick_step   = 10'd1;
        tbl_now     = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_armed[i]  = 1'b0;
            tbl_handle[i] = '0;
            tbl_due[i]    = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_gap_max = 3;
        sink_gap_max = 3;
        test_idle_tick();
        test_arm_limits();
        test_cancel_lookup();
        test_table_full();

        test_random_traffic(70, 10'd1, 16, 16);
        test_random_traffic(50, 10'd0, 0, 0);
        test_random_traffic(60, 10'd1023, 0, 16);
        test_random_traffic(70, MS_W'($urandom_range(1, 1000)), 16, 0);
        test_output_backpressure();
        test_random_traffic(60, 10'd1, 8, 8);

        // Drain what is still owed, then watch for stray words
        guard = 0;
        while (pending_words.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
            fail_count += pending_words.size();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
